// ===== hdl/dtdt_pkg.sv =====
// ----------------------------------------------------------------------------
// dtdt_pkg
// Shared types and constants for the double to decimal text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dtdt_pkg;

  localparam logic [7:0]  CHAR_ZERO   = 8'h30;
  localparam logic [7:0]  CHAR_DOT    = 8'h2E;
  localparam logic [7:0]  CHAR_MINUS  = 8'h2D;
  localparam logic [7:0]  CHAR_NONE   = 8'h00;
  localparam int unsigned DEC_DIGITS  = 19;
  // largest fraction value (2^-37 units) not above 0.0001
  localparam logic [37:0] FRAC_THRESH = 38'd13743895;

  typedef enum logic [2:0] {
    CH_ERR,
    CH_MINUS,
    CH_INT,
    CH_DOT,
    CH_FRAC
  } char_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROUND0,
    ST_ERR,
    ST_MINUS,
    ST_CONV,
    ST_SKIP,
    ST_INT,
    ST_DOT,
    ST_FMUL,
    ST_FDIG
  } state_e;

  typedef struct packed {
    logic      load;
    logic      round0;
    logic      dabble;
    logic      skip;
    logic      fmul;
    logic      emit;
    char_sel_e sel;
    logic      last;
  } dtdt_cmd_t;

  typedef struct packed {
    logic err;
    logic neg;
    logic bits_zero;
    logic top_zero;
    logic digits_one;
    logic frac_more;
    logic next_small;
    logic out_free;
  } dtdt_stat_t;

endpackage

`default_nettype wire

// ===== hdl/double_to_decimal_text_top.sv =====
// ----------------------------------------------------------------------------
// double_to_decimal_text_top
// Binary64 bit pattern in, decimal ASCII text out, one character per beat.
// ----------------------------------------------------------------------------
// Per number: load, round the fraction to 24 significant bits, then either
// an error beat, or an optional minus sign, binary to BCD over the integer
// bits, leading-zero skip, integer digits and, with a fraction, the point
// and per fraction digit a times-ten step followed by a round step.
// One number in flight; input ready only in idle. Reset clears control.
// ----------------------------------------------------------------------------
`default_nettype none

module double_to_decimal_text_top #(
  parameter int unsigned MAX_TEXT_CHARS = 63
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [63:0] s_axis_tdata_i,   // [63:0] value_bits
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] char_code
  output logic        m_axis_tlast_o,   // last_char
  output logic        m_axis_tuser_o    // [0] range_error
);

  dtdt_pkg::dtdt_cmd_t  cmd;
  dtdt_pkg::dtdt_stat_t stat;

  dtdt_ctrl #(
    .MAX_TEXT_CHARS(MAX_TEXT_CHARS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dtdt_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_bits_i  (s_axis_tdata_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .char_code_o   (m_axis_tdata_o),
    .last_char_o   (m_axis_tlast_o),
    .range_error_o (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ===== hdl/dtdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtdt_ctrl
// Sequencer: conversion steps and character emission order.
// ----------------------------------------------------------------------------
`default_nettype none

module dtdt_ctrl #(
  parameter int unsigned MAX_TEXT_CHARS = 63
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  dtdt_pkg::dtdt_stat_t stat_i,
  output dtdt_pkg::dtdt_cmd_t  cmd_o
);

  localparam int unsigned CW = $clog2(MAX_TEXT_CHARS + 1);

  dtdt_pkg::state_e state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             cnt_last;

  assign cnt_last = (cnt_q == CW'(MAX_TEXT_CHARS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtdt_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.sel  = dtdt_pkg::CH_ERR;
    unique case (state_q)
      dtdt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = dtdt_pkg::ST_ROUND0;
        end
      end
      dtdt_pkg::ST_ROUND0: begin
        cmd_o.round0 = 1'b1;
        if (stat_i.err)      state_d = dtdt_pkg::ST_ERR;
        else if (stat_i.neg) state_d = dtdt_pkg::ST_MINUS;
        else                 state_d = dtdt_pkg::ST_CONV;
      end
      dtdt_pkg::ST_ERR: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = dtdt_pkg::CH_ERR;
          cmd_o.last = 1'b1;
          state_d    = dtdt_pkg::ST_IDLE;
        end
      end
      dtdt_pkg::ST_MINUS: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = dtdt_pkg::CH_MINUS;
          cmd_o.last = cnt_last;
          cnt_d      = cnt_q + CW'(1);
          state_d    = cnt_last ? dtdt_pkg::ST_IDLE : dtdt_pkg::ST_CONV;
        end
      end
      dtdt_pkg::ST_CONV: begin
        if (stat_i.bits_zero) state_d = dtdt_pkg::ST_SKIP;
        else                  cmd_o.dabble = 1'b1;
      end
      dtdt_pkg::ST_SKIP: begin
        if (stat_i.top_zero && !stat_i.digits_one) cmd_o.skip = 1'b1;
        else                                       state_d = dtdt_pkg::ST_INT;
      end
      dtdt_pkg::ST_INT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = dtdt_pkg::CH_INT;
          cmd_o.last = (stat_i.digits_one && !stat_i.frac_more) || cnt_last;
          cnt_d      = cnt_q + CW'(1);
          if (cmd_o.last)             state_d = dtdt_pkg::ST_IDLE;
          else if (stat_i.digits_one) state_d = dtdt_pkg::ST_DOT;
        end
      end
      dtdt_pkg::ST_DOT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = dtdt_pkg::CH_DOT;
          cmd_o.last = cnt_last;
          cnt_d      = cnt_q + CW'(1);
          state_d    = cnt_last ? dtdt_pkg::ST_IDLE : dtdt_pkg::ST_FMUL;
        end
      end
      dtdt_pkg::ST_FMUL: begin
        cmd_o.fmul = 1'b1;
        state_d    = dtdt_pkg::ST_FDIG;
      end
      dtdt_pkg::ST_FDIG: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = dtdt_pkg::CH_FRAC;
          cmd_o.last = stat_i.next_small || cnt_last;
          cnt_d      = cnt_q + CW'(1);
          state_d    = cmd_o.last ? dtdt_pkg::ST_IDLE : dtdt_pkg::ST_FMUL;
        end
      end
      default: state_d = dtdt_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/dtdt_dp.sv =====
// ----------------------------------------------------------------------------
// dtdt_dp
// Datapath: field unpack, binary to BCD, binary32 fraction digits, output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module dtdt_dp (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire  [63:0]          value_bits_i,
  input  dtdt_pkg::dtdt_cmd_t  cmd_i,
  output dtdt_pkg::dtdt_stat_t stat_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [7:0]           char_code_o,
  output logic                 last_char_o,
  output logic                 range_error_o
);

  localparam int unsigned BW = 4 * dtdt_pkg::DEC_DIGITS;

  // round to 24 significant bits, ulp at bit s, nearest even
  function automatic logic [66:0] round_sig(input logic [66:0] x, input logic [6:0] s);
    logic [66:0] ulp;
    logic [66:0] half;
    logic [66:0] low;
    logic [66:0] trunc;
    logic        up;
    ulp   = 67'd1 << s;
    half  = ulp >> 1;
    low   = x & (ulp - 67'd1);
    trunc = x & ~(ulp - 67'd1);
    up    = (low > half) || ((low == half) && ((x & ulp) != '0));
    return trunc + (up ? ulp : 67'd0);
  endfunction

  function automatic logic [3:0] lead14(input logic [13:0] v);
    logic [3:0] p;
    p = '0;
    for (int i = 0; i < 14; i++) begin
      if (v[i]) p = 4'(i);
    end
    return p;
  endfunction

  logic          err_q, neg_q;
  logic [6:0]    bitcnt_q;
  logic [62:0]   ibits_q;
  logic [65:0]   g_q;
  logic [BW-1:0] bcd_q;
  logic [4:0]    dleft_q;
  logic [37:0]   r_q;
  logic [40:0]   p_q;
  logic          out_valid_q;
  logic [7:0]    char_q;
  logic          last_q, rerr_q;

  logic [10:0]   expf;
  logic [52:0]   mant;
  logic [65:0]   g_load;
  logic [BW-1:0] bcd_adj;
  logic [66:0]   r0_rnd;
  logic [66:0]   p_rnd;
  logic [4:0]    dval;
  logic [3:0]    digit;
  logic [37:0]   r_next;
  logic [7:0]    char_d;
  logic          out_free;

  assign expf = value_bits_i[62:52];
  assign mant = {(expf != 11'd0), value_bits_i[51:0]};

  always_comb begin
    if (expf >= 11'd1009 && expf <= 11'd1074) g_load = 66'(mant) << (expf - 11'd1009);
    else                                      g_load = '0;
  end

  always_comb begin
    for (int k = 0; k < dtdt_pkg::DEC_DIGITS; k++) begin
      bcd_adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3
                                                    : bcd_q[4*k +: 4];
    end
  end

  assign r0_rnd = round_sig({1'b0, g_q}, 7'd29 + 7'(lead14(g_q[65:52])));
  assign p_rnd  = round_sig(67'(p_q), 7'd4 + 7'(lead14(p_q[40:27])));
  assign dval   = p_rnd[41:37];
  assign digit  = (dval >= 5'd10) ? 4'(dval - 5'd10) : dval[3:0];
  assign r_next = {1'b0, p_rnd[36:0]};

  always_comb begin
    unique case (cmd_i.sel)
      dtdt_pkg::CH_ERR:   char_d = dtdt_pkg::CHAR_NONE;
      dtdt_pkg::CH_MINUS: char_d = dtdt_pkg::CHAR_MINUS;
      dtdt_pkg::CH_INT:   char_d = dtdt_pkg::CHAR_ZERO + 8'(bcd_q[BW-1 -: 4]);
      dtdt_pkg::CH_DOT:   char_d = dtdt_pkg::CHAR_DOT;
      dtdt_pkg::CH_FRAC:  char_d = dtdt_pkg::CHAR_ZERO + 8'(digit);
      default:            char_d = dtdt_pkg::CHAR_NONE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q    <= (expf >= 11'd1086);
      neg_q    <= value_bits_i[63] && (value_bits_i[62:0] != 63'd0);
      bitcnt_q <= (expf >= 11'd1023 && expf <= 11'd1085) ? 7'(expf - 11'd1022) : 7'd0;
      ibits_q  <= {mant, 10'd0};
      g_q      <= g_load;
      bcd_q    <= '0;
      dleft_q  <= 5'(dtdt_pkg::DEC_DIGITS);
    end
    if (cmd_i.round0) begin
      r_q <= (g_q[65:52] == '0) ? 38'd0 : r0_rnd[66:29];
    end
    if (cmd_i.dabble) begin
      bcd_q    <= {bcd_adj[BW-2:0], ibits_q[62]};
      ibits_q  <= {ibits_q[61:0], 1'b0};
      bitcnt_q <= bitcnt_q - 7'd1;
    end
    if (cmd_i.skip || (cmd_i.emit && cmd_i.sel == dtdt_pkg::CH_INT)) begin
      bcd_q   <= {bcd_q[BW-5:0], 4'd0};
      dleft_q <= dleft_q - 5'd1;
    end
    if (cmd_i.fmul) begin
      p_q <= {r_q, 3'd0} + {2'd0, r_q, 1'd0};
    end
    if (cmd_i.emit && cmd_i.sel == dtdt_pkg::CH_FRAC) begin
      r_q <= r_next;
    end
    if (cmd_i.emit) begin
      char_q <= char_d;
      last_q <= cmd_i.last;
      rerr_q <= (cmd_i.sel == dtdt_pkg::CH_ERR);
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    stat_o.err        = err_q;
    stat_o.neg        = neg_q;
    stat_o.bits_zero  = (bitcnt_q == 7'd0);
    stat_o.top_zero   = (bcd_q[BW-1 -: 4] == 4'd0);
    stat_o.digits_one = (dleft_q == 5'd1);
    stat_o.frac_more  = (r_q > dtdt_pkg::FRAC_THRESH);
    stat_o.next_small = (r_next <= dtdt_pkg::FRAC_THRESH);
    stat_o.out_free   = out_free;
  end

  assign out_valid_o   = out_valid_q;
  assign char_code_o   = char_q;
  assign last_char_o   = last_q;
  assign range_error_o = rerr_q;

endmodule

`default_nettype wire

// ===== hdl/dtdt_checker.sv =====
// ----------------------------------------------------------------------------
// dtdt_checker
// Port-level checks for the double to decimal text converter.
// ----------------------------------------------------------------------------
`default_nettype none

module dtdt_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       s_axis_tvalid_i,
  input wire       s_axis_tready_o,
  input wire       m_axis_tvalid_o,
  input wire       m_axis_tready_i,
  input wire [7:0] m_axis_tdata_o,
  input wire       m_axis_tlast_o,
  input wire       m_axis_tuser_o
);

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o && (m_axis_tdata_o == 8'h00))
    else $error("error transaction not a lone zero character");

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      (m_axis_tdata_o == 8'h2D) || (m_axis_tdata_o == 8'h2E) ||
      ((m_axis_tdata_o >= 8'h30) && (m_axis_tdata_o <= 8'h39)))
    else $error("unexpected character code");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while a number is in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output transaction changed");

endmodule

bind double_to_decimal_text_top dtdt_checker u_dtdt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
